@@ rtl/core/cbc_pkg.sv @@
// Package of the crossfading block convolver: command codes, back-end states,
// status struct and the crossfade weight function. Depends on nothing.
`timescale 1ns / 1ps

package cbc_pkg;

	// Depth of the command queue between front and back end.
	localparam int QDEPTH = 2;

	// Width of the requested response index carried by an input item.
	localparam int SEL_W = 3;

	// Width of a crossfade weight, unsigned Q15 from 0 to 32768.
	localparam int W_BITS = 16;

	// Fixed-point constants for the weight table.
	localparam longint Q30_ONE     = 64'sd1 <<< 30;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;

	// What the front end made of an accepted item.
	typedef enum logic [1:0] {
		CMD_SAMPLE,
		CMD_COEF,
		CMD_SKIP
	} cmd_kind_e;

	// Back-end sequencer states.
	typedef enum logic [3:0] {
		BS_IDLE,
		BS_SMP_RD,
		BS_BLK,
		BS_PASS_A,
		BS_DRAIN_A,
		BS_PASS_B,
		BS_DRAIN_B,
		BS_W_CUR,
		BS_W_NXT,
		BS_W_SUM,
		BS_FINISH
	} back_state_e;

	// Status that the back end hands to the front end.
	typedef struct packed {
		logic cmd_ready;
		logic blk_busy;
	} cbc_stat_t;

	// cos^2 of an angle in Q30, rounded to Q15. Taylor series to u^12,
	// Horner form with truncating steps, clamped at zero. Elaboration only.
	function automatic longint cos_sq_q15(longint u);
		longint u2;
		longint t;
		longint q;
		u2 = (u * u) >>> 30;
		t  = Q30_ONE;
		for (int j = 0; j < 6; j++) begin
			q = (u2 * t) >>> 30;
			case (j)
				0: q = q / 132;
				1: q = q / 90;
				2: q = q / 56;
				3: q = q / 30;
				4: q = q / 12;
				default: q = q / 2;
			endcase
			t = Q30_ONE - q;
			if (t < 0) begin
				t = 0;
			end
		end
		return (((t * t) >>> 30) + (64'sd1 <<< 14)) >>> 15;
	endfunction

endpackage

@@ rtl/core/cbc_item_if.sv @@
// Valid/ready channel interfaces for input items and result items.
// Depends on nothing; widths are set where the channels are instantiated.
`timescale 1ns / 1ps

interface cbc_item_if #(
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 16,
	parameter int SEL_W       = 3,
	parameter int BANK_W      = 2,
	parameter int IDX_W       = 6
);
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic [SEL_W-1:0]              ir_select;
	logic [BANK_W-1:0]             coef_bank;
	logic [IDX_W-1:0]              coef_index;
	logic signed [COEF_BITS-1:0]   coef_value;

	modport source (
		output valid, kind, sample, ir_select, coef_bank, coef_index, coef_value,
		input  ready
	);
	modport sink (
		input  valid, kind, sample, ir_select, coef_bank, coef_index, coef_value,
		output ready
	);
endinterface

interface cbc_result_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] out_sample;
	logic                          saturated;

	modport source (output valid, out_sample, saturated, input ready);
	modport sink (input valid, out_sample, saturated, output ready);
endinterface

@@ rtl/core/cbc_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module cbc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/core/cbc_front.sv @@
// Front end: accepts input items, classifies them into commands and queues
// them for the back end. Depends on cbc_pkg and cbc_item_if.
`timescale 1ns / 1ps

module cbc_front #(
	parameter int TAPS        = 64,
	parameter int BANKS       = 4,
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 16
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	cbc_item_if.sink                                         items,
	input  cbc_pkg::cbc_stat_t                               stat,
	output logic                                             cmd_valid,
	output cbc_pkg::cmd_kind_e                               cmd_kind,
	output logic signed [SAMPLE_BITS-1:0]                    cmd_sample,
	output logic [cbc_pkg::SEL_W-1:0]                        cmd_sel,
	output logic [$clog2(BANKS*TAPS)-1:0]                    cmd_addr,
	output logic signed [COEF_BITS-1:0]                      cmd_coef
);
	import cbc_pkg::*;

	localparam int RSP_AW = $clog2(BANKS*TAPS);
	localparam int PTR_W  = $clog2(QDEPTH);
	localparam int CNT_W  = $clog2(QDEPTH + 1);

	cmd_kind_e                     kind_q   [QDEPTH];
	logic signed [SAMPLE_BITS-1:0] sample_q [QDEPTH];
	logic [SEL_W-1:0]              sel_q    [QDEPTH];
	logic [RSP_AW-1:0]             addr_q   [QDEPTH];
	logic signed [COEF_BITS-1:0]   coef_q   [QDEPTH];

	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic      push;
	logic      pop;
	cmd_kind_e new_kind;
	logic      coef_ok;

	// A coefficient load outside the bank or the tap range is dropped.
	always_comb begin
		coef_ok = (int'(items.coef_bank) < BANKS) && (int'(items.coef_index) < TAPS);
		if (!items.kind) begin
			new_kind = CMD_SAMPLE;
		end else if (coef_ok) begin
			new_kind = CMD_COEF;
		end else begin
			new_kind = CMD_SKIP;
		end
	end

	assign items.ready = (count_q != CNT_W'(QDEPTH));
	assign push        = items.valid && items.ready;
	assign pop         = cmd_valid && stat.cmd_ready;

	// Queue storage; payload needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			kind_q[wr_ptr_q]   <= new_kind;
			sample_q[wr_ptr_q] <= items.sample;
			sel_q[wr_ptr_q]    <= items.ir_select;
			addr_q[wr_ptr_q]   <= RSP_AW'(int'(items.coef_bank) * TAPS +
				int'(items.coef_index));
			coef_q[wr_ptr_q]   <= items.coef_value;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= PTR_W'((int'(wr_ptr_q) + 1) % QDEPTH);
			end
			if (pop) begin
				rd_ptr_q <= PTR_W'((int'(rd_ptr_q) + 1) % QDEPTH);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign cmd_valid  = (count_q != '0);
	assign cmd_kind   = kind_q[rd_ptr_q];
	assign cmd_sample = sample_q[rd_ptr_q];
	assign cmd_sel    = sel_q[rd_ptr_q];
	assign cmd_addr   = addr_q[rd_ptr_q];
	assign cmd_coef   = coef_q[rd_ptr_q];
endmodule

@@ rtl/core/cbc_back.sv @@
// Back end: executes queued commands, runs the block convolution on one shared
// multiplier, weights the crossfade on two more and holds the result register.
// Depends on cbc_pkg, cbc_item_if (result channel) and cbc_ram.
`timescale 1ns / 1ps

module cbc_back #(
	parameter int TAPS        = 64,
	parameter int BANKS       = 4,
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        cmd_valid,
	input  cbc_pkg::cmd_kind_e                          cmd_kind,
	input  logic signed [SAMPLE_BITS-1:0]               cmd_sample,
	input  logic [cbc_pkg::SEL_W-1:0]                   cmd_sel,
	input  logic [$clog2(BANKS*TAPS)-1:0]               cmd_addr,
	input  logic signed [COEF_BITS-1:0]                 cmd_coef,
	output cbc_pkg::cbc_stat_t                          stat,
	cbc_result_if.source                                results
);
	import cbc_pkg::*;

	localparam int IDX_W  = $clog2(TAPS);
	localparam int BANK_W = (BANKS > 1) ? $clog2(BANKS) : 1;
	localparam int RSP_AW = $clog2(BANKS*TAPS);
	localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_W  = PROD_W + IDX_W;
	localparam int HI_W   = ACC_W - 15;
	localparam int VAL_W  = ACC_W + 2;
	localparam int YW     = ACC_W + 3;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAPS - 1);
	localparam logic signed [YW-1:0] SAT_HI = YW'((64'sd1 <<< (SAMPLE_BITS-1)) - 1);
	localparam logic signed [YW-1:0] SAT_LO = YW'(-(64'sd1 <<< (SAMPLE_BITS-1)));
	localparam logic signed [YW-1:0] RND    = YW'(64'sd1 <<< (COEF_BITS-2));

	// Crossfade weight table, worked out at elaboration.
	logic [W_BITS-1:0] fade_w [TAPS];
	for (genvar gi = 0; gi < TAPS; gi++) begin : g_fade
		localparam longint U = (longint'(gi) * HALF_PI_Q30) / TAPS;
		assign fade_w[gi] = W_BITS'(cos_sq_q15(U));
	end

	back_state_e state_q, state_d;

	logic [IDX_W-1:0]  pos_q;
	logic [IDX_W-1:0]  n_q;
	logic [IDX_W-1:0]  k_q;
	logic [SEL_W-1:0]  pend_q;
	logic [BANK_W-1:0] cur_q;
	logic [BANK_W-1:0] next_q;
	logic              change_q;
	logic              pass_b_q;
	logic              first_q;

	logic                     v_s1, inblk_s1;
	logic                     v_s2, inblk_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic signed [ACC_W-1:0] in_acc_q;
	logic signed [ACC_W-1:0] tail_acc_q;
	logic signed [ACC_W-1:0] cur_acc_q;

	logic                       wneg_q;
	logic [HI_W+W_BITS-1:0]     whi_q;
	logic [15+W_BITS-1:0]       wlo_q;
	logic signed [ACC_W:0]      wc_q;
	logic signed [VAL_W-1:0]    val_q;

	logic                          res_v_q;
	logic signed [SAMPLE_BITS-1:0] res_sample_q;
	logic                          res_sat_q;

	logic                          pop;
	logic                          res_load;
	logic                          issue;
	logic                          pipe_empty;
	logic                          last_k;
	logic [BANK_W-1:0]             sel_next;
	logic [IDX_W:0]                dd;
	logic [IDX_W-1:0]              d;
	logic [BANK_W-1:0]             mac_bank;

	logic                          in_we;
	logic signed [SAMPLE_BITS-1:0] in_rdata;
	logic                          rsp_we;
	logic [RSP_AW-1:0]             rsp_raddr;
	logic signed [COEF_BITS-1:0]   rsp_rdata;
	logic                          fin;
	logic [SAMPLE_BITS:0]          out_wdata;
	logic [SAMPLE_BITS:0]          out_rdata;
	logic signed [ACC_W-1:0]       tail_rdata;

	logic signed [ACC_W-1:0] wsrc;
	logic [W_BITS-1:0]       wsel;
	logic [ACC_W-1:0]        wabs;
	logic [ACC_W-1:0]        wmag;
	logic signed [ACC_W:0]   wsigned;

	logic signed [YW-1:0] tail_old;
	logic signed [YW-1:0] yv;
	logic signed [YW-1:0] rv;
	logic                 clip;
	logic signed [SAMPLE_BITS-1:0] rsat;

	// Memories: response bank, input block, output block, tail.
	cbc_ram #(.WIDTH(COEF_BITS), .DEPTH(BANKS*TAPS)) u_rsp (
		.clk(clk), .we(rsp_we), .waddr(cmd_addr), .wdata(cmd_coef),
		.raddr(rsp_raddr), .rdata(rsp_rdata)
	);
	cbc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(TAPS)) u_in (
		.clk(clk), .we(in_we), .waddr(pos_q), .wdata(cmd_sample),
		.raddr(k_q), .rdata(in_rdata)
	);
	cbc_ram #(.WIDTH(SAMPLE_BITS+1), .DEPTH(TAPS)) u_out (
		.clk(clk), .we(fin), .waddr(n_q), .wdata(out_wdata),
		.raddr(pos_q), .rdata(out_rdata)
	);
	cbc_ram #(.WIDTH(ACC_W), .DEPTH(TAPS)) u_tail (
		.clk(clk), .we(fin), .waddr(n_q), .wdata(tail_acc_q),
		.raddr(n_q), .rdata(tail_rdata)
	);

	// Command handshake and memory write strobes.
	assign pop    = cmd_valid && (state_q == BS_IDLE);
	assign rsp_we = pop && (cmd_kind == CMD_COEF);
	assign in_we  = pop && (cmd_kind == CMD_SAMPLE);
	assign fin    = (state_q == BS_FINISH);

	assign stat.cmd_ready = (state_q == BS_IDLE);
	assign stat.blk_busy  = !((state_q == BS_IDLE) || (state_q == BS_SMP_RD));

	assign res_load = (state_q == BS_SMP_RD) && (!res_v_q || results.ready);

	// Multiply-accumulate issue: tap index wraps so one pass yields in-block and tail.
	assign issue      = (state_q == BS_PASS_A) || (state_q == BS_PASS_B);
	assign pipe_empty = !v_s1 && !v_s2;
	assign last_k     = (state_q == BS_PASS_A) ? (k_q == LAST_IDX) : (k_q == n_q);
	assign sel_next   = (int'(pend_q) < BANKS) ? BANK_W'(pend_q) : cur_q;
	assign mac_bank   = pass_b_q ? cur_q : next_q;

	always_comb begin
		dd = {1'b0, n_q} - {1'b0, k_q};
		if (n_q < k_q) begin
			dd = dd + (IDX_W+1)'(TAPS);
		end
		d         = dd[IDX_W-1:0];
		rsp_raddr = RSP_AW'(int'(mac_bank) * TAPS + int'(d));
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			BS_IDLE: begin
				if (pop && (cmd_kind == CMD_SAMPLE)) begin
					state_d = BS_SMP_RD;
				end
			end
			BS_SMP_RD: begin
				if (res_load) begin
					state_d = (pos_q == LAST_IDX) ? BS_BLK : BS_IDLE;
				end
			end
			BS_BLK:    state_d = BS_PASS_A;
			BS_PASS_A: begin
				if (last_k) begin
					state_d = BS_DRAIN_A;
				end
			end
			BS_DRAIN_A: begin
				if (pipe_empty) begin
					state_d = change_q ? BS_PASS_B : BS_FINISH;
				end
			end
			BS_PASS_B: begin
				if (last_k) begin
					state_d = BS_DRAIN_B;
				end
			end
			BS_DRAIN_B: begin
				if (pipe_empty) begin
					state_d = BS_W_CUR;
				end
			end
			BS_W_CUR:  state_d = BS_W_NXT;
			BS_W_NXT:  state_d = BS_W_SUM;
			BS_W_SUM:  state_d = BS_FINISH;
			BS_FINISH: state_d = (n_q == LAST_IDX) ? BS_IDLE : BS_PASS_A;
			default:   state_d = BS_IDLE;
		endcase
	end

	// Control registers: block position, output index, tap counter, selection.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			n_q      <= '0;
			k_q      <= '0;
			pend_q   <= '0;
			cur_q    <= '0;
			next_q   <= '0;
			change_q <= 1'b0;
			pass_b_q <= 1'b0;
			first_q  <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			res_v_q  <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (in_we) begin
				pend_q <= cmd_sel;
			end
			if (res_load) begin
				pos_q <= (pos_q == LAST_IDX) ? '0 : pos_q + 1'b1;
			end
			if (res_load) begin
				res_v_q <= 1'b1;
			end else if (results.ready) begin
				res_v_q <= 1'b0;
			end
			case (state_q)
				BS_BLK: begin
					next_q   <= sel_next;
					change_q <= (sel_next != cur_q);
					n_q      <= '0;
					k_q      <= '0;
					pass_b_q <= 1'b0;
				end
				BS_PASS_A, BS_PASS_B: begin
					k_q <= last_k ? '0 : k_q + 1'b1;
				end
				BS_DRAIN_A: begin
					if (pipe_empty) begin
						pass_b_q <= 1'b1;
					end
				end
				BS_FINISH: begin
					pass_b_q <= 1'b0;
					if (n_q == LAST_IDX) begin
						n_q     <= '0;
						cur_q   <= next_q;
						first_q <= 1'b1;
					end else begin
						n_q <= n_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Product pipeline and accumulators.
	always_ff @(posedge clk) begin
		inblk_s1 <= (k_q <= n_q);
		inblk_s2 <= inblk_s1;
		prod_s2  <= PROD_W'(in_rdata * rsp_rdata);
		if ((state_q == BS_BLK) || (state_q == BS_FINISH)) begin
			in_acc_q   <= '0;
			tail_acc_q <= '0;
			cur_acc_q  <= '0;
		end else if (v_s2) begin
			if (pass_b_q) begin
				cur_acc_q <= cur_acc_q + ACC_W'(prod_s2);
			end else if (inblk_s2) begin
				in_acc_q <= in_acc_q + ACC_W'(prod_s2);
			end else begin
				tail_acc_q <= tail_acc_q + ACC_W'(prod_s2);
			end
		end
	end

	// Crossfade weighting: magnitude split in two partial products, truncated toward zero.
	always_comb begin
		wsrc    = (state_q == BS_W_CUR) ? cur_acc_q : in_acc_q;
		wsel    = (state_q == BS_W_CUR) ? fade_w[n_q] : fade_w[LAST_IDX - n_q];
		wabs    = wsrc[ACC_W-1] ? ACC_W'(-wsrc) : ACC_W'(wsrc);
		wmag    = ACC_W'(whi_q) + ACC_W'(wlo_q >> 15);
		wsigned = wneg_q ? -$signed({1'b0, wmag}) : $signed({1'b0, wmag});
	end

	always_ff @(posedge clk) begin
		if ((state_q == BS_W_CUR) || (state_q == BS_W_NXT)) begin
			wneg_q <= wsrc[ACC_W-1];
			whi_q  <= wabs[ACC_W-1:15] * wsel;
			wlo_q  <= wabs[14:0] * wsel;
		end
		if (state_q == BS_W_NXT) begin
			wc_q <= wsigned;
		end
		if (state_q == BS_W_SUM) begin
			val_q <= VAL_W'(wc_q) + VAL_W'(wsigned);
		end
	end

	// Add the saved tail, round to the sample format and saturate.
	always_comb begin
		tail_old = first_q ? YW'(tail_rdata) : '0;
		yv       = tail_old + (change_q ? YW'(val_q) : YW'(in_acc_q)) + RND;
		rv       = yv >>> (COEF_BITS - 1);
		clip     = 1'b0;
		rsat     = SAMPLE_BITS'(rv);
		if (rv > SAT_HI) begin
			clip = 1'b1;
			rsat = SAMPLE_BITS'(SAT_HI);
		end else if (rv < SAT_LO) begin
			clip = 1'b1;
			rsat = SAMPLE_BITS'(SAT_LO);
		end
		out_wdata = {clip, rsat};
	end

	// Result register; the output block reads as zeros before the first block ends.
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_sample_q <= first_q ? out_rdata[SAMPLE_BITS-1:0] : '0;
			res_sat_q    <= first_q ? out_rdata[SAMPLE_BITS] : 1'b0;
		end
	end

	assign results.valid      = res_v_q;
	assign results.out_sample = res_sample_q;
	assign results.saturated  = res_sat_q;
endmodule

@@ rtl/core/crossfading_block_convolver.sv @@
// Channel  | Direction | Payload
// items    | in        | kind, sample, ir_select, coef_bank, coef_index, coef_value
// results  | out       | out_sample, saturated
//
// The last sample of a block starts the convolution on the shared multiplier:
// for each output index n of the block of TAPS samples, one pass over all taps
// of the new response, plus a pass over taps 0 to n of the old response and a
// crossfade weighting step when the response changes.
// arst_n clears control state; output and tail read as zero until the first
// block is done. A two-entry queue lets input and result stall independently.
// Depends on cbc_pkg, cbc_item_if, cbc_front and cbc_back.
`timescale 1ns / 1ps

module crossfading_block_convolver #(
	parameter int TAPS        = 64,
	parameter int BANKS       = 4,
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	cbc_item_if.sink      items,
	cbc_result_if.source  results
);
	import cbc_pkg::*;

	localparam int RSP_AW = $clog2(BANKS*TAPS);

	cbc_stat_t                     stat;
	logic                          cmd_valid;
	cmd_kind_e                     cmd_kind;
	logic signed [SAMPLE_BITS-1:0] cmd_sample;
	logic [SEL_W-1:0]              cmd_sel;
	logic [RSP_AW-1:0]             cmd_addr;
	logic signed [COEF_BITS-1:0]   cmd_coef;

	// Front end with the command queue.
	cbc_front #(
		.TAPS(TAPS), .BANKS(BANKS), .SAMPLE_BITS(SAMPLE_BITS), .COEF_BITS(COEF_BITS)
	) u_front (
		.clk(clk), .arst_n(arst_n), .items(items), .stat(stat),
		.cmd_valid(cmd_valid), .cmd_kind(cmd_kind), .cmd_sample(cmd_sample),
		.cmd_sel(cmd_sel), .cmd_addr(cmd_addr), .cmd_coef(cmd_coef)
	);

	// Back end with the convolution engine.
	cbc_back #(
		.TAPS(TAPS), .BANKS(BANKS), .SAMPLE_BITS(SAMPLE_BITS), .COEF_BITS(COEF_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_kind(cmd_kind),
		.cmd_sample(cmd_sample), .cmd_sel(cmd_sel), .cmd_addr(cmd_addr),
		.cmd_coef(cmd_coef), .stat(stat), .results(results)
	);

`ifndef SYNTHESIS
	// No command is taken while a block is being convolved.
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.blk_busy |-> !(cmd_valid && stat.cmd_ready))
		else $error("command taken during block convolution");

	// A coefficient or dropped command never produces a result on its own.
	a_coef_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && stat.cmd_ready && (cmd_kind != CMD_SAMPLE)) |=> !$rose(results.valid))
		else $error("result raised by a non-sample command");
`endif
endmodule

@@ tb/cbc_conv_checker.sv @@
// Checker for the crossfading block convolver: watches both channels, predicts each result.
// It compares the results in order. Depends on cbc_item_if and cbc_result_if.
`timescale 1ns / 1ps

module cbc_conv_checker #(
	parameter int TAPS        = 64,
	parameter int BANKS       = 4,
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	cbc_item_if   items,
	cbc_result_if results,
	output int    fail_count,
	output int    pending,
	output int    result_count,
	output int    fade_count,
	output int    clip_count
);

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] smp;
		logic                          sat;
	} out_item_t;

	localparam longint ONE_Q30  = 64'sd1 <<< 30;
	localparam longint QUARTER  = 64'sd1686629713;

	// Model state of the convolver.
	longint    coef_mem [BANKS*TAPS];
	longint    in_blk [TAPS];
	logic signed [SAMPLE_BITS-1:0] out_blk [TAPS];
	logic      clip_blk [TAPS];
	longint    tail_sum [TAPS];
	longint    fade_w [TAPS];
	int        cur_resp;
	int        blk_pos;
	int        pend_sel;
	out_item_t expected_q [$];

	// cos^2 crossfade weight in unsigned Q15 from an angle in Q30.
	function automatic longint fade_weight_of(longint u);
		longint u2;
		longint t;
		longint dv [6];
		dv = '{132, 90, 56, 30, 12, 2};
		u2 = (u * u) >>> 30;
		t  = ONE_Q30;
		for (int j = 0; j < 6; j++) begin
			t = ONE_Q30 - ((u2 * t) >>> 30) / dv[j];
			if (t < 0) begin
				t = 0;
			end
		end
		return (((t * t) >>> 30) + (64'sd1 <<< 14)) >>> 15;
	endfunction

	// Weighted value, truncated toward zero.
	function automatic longint scale_by(longint v, longint w);
		longint m;
		longint r;
		m = (v < 0) ? -v : v;
		r = (m >>> 15) * w + (((m & 64'sh7fff) * w) >>> 15);
		return (v < 0) ? -r : r;
	endfunction

	// Partial convolution of the input block with one stored response.
	function automatic longint conv_sum(int bank, int n, int lo);
		longint acc;
		acc = 0;
		for (int k = lo; k < TAPS; k++) begin
			if (n - k >= 0 && n - k < TAPS) begin
				acc += in_blk[k] * coef_mem[bank*TAPS + n - k];
			end
		end
		return acc;
	endfunction

	// Block end: new output block and new tail, with crossfade on a change.
	task automatic close_block();
		int     nxt;
		bit     change;
		longint val;
		longint r;
		nxt    = (pend_sel < BANKS) ? pend_sel : cur_resp;
		change = (nxt != cur_resp);
		if (change) begin
			fade_count++;
		end
		for (int n = 0; n < TAPS; n++) begin
			val = conv_sum(nxt, n, 0);
			if (change) begin
				val = scale_by(conv_sum(cur_resp, n, 0), fade_w[n])
					+ scale_by(val, fade_w[TAPS-1-n]);
			end
			r = (tail_sum[n] + val + (64'sd1 <<< (COEF_BITS-2))) >>> (COEF_BITS-1);
			clip_blk[n] = 1'b0;
			if (r > (64'sd1 <<< (SAMPLE_BITS-1)) - 1) begin
				r = (64'sd1 <<< (SAMPLE_BITS-1)) - 1;
				clip_blk[n] = 1'b1;
			end
			if (r < -(64'sd1 <<< (SAMPLE_BITS-1))) begin
				r = -(64'sd1 <<< (SAMPLE_BITS-1));
				clip_blk[n] = 1'b1;
			end
			out_blk[n] = r[SAMPLE_BITS-1:0];
		end
		for (int n = 0; n < TAPS - 1; n++) begin
			tail_sum[n] = conv_sum(nxt, TAPS + n, n + 1);
		end
		tail_sum[TAPS-1] = 0;
		cur_resp = nxt;
	endtask

	assign pending = expected_q.size();

	// Follow every transfer on both channels; items before results in one cycle.
	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				in_blk[i]   = 0;
				out_blk[i]  = '0;
				clip_blk[i] = 1'b0;
				tail_sum[i] = 0;
				fade_w[i]   = fade_weight_of((longint'(i) * QUARTER) / TAPS);
			end
			for (int i = 0; i < BANKS*TAPS; i++) begin
				coef_mem[i] = 0;
			end
			cur_resp = 0;
			blk_pos  = 0;
			pend_sel = 0;
			expected_q.delete();
			fail_count   = 0;
			result_count = 0;
			fade_count   = 0;
			clip_count   = 0;
		end else begin
			if (items.valid && items.ready) begin
				if (items.kind) begin
					if (items.coef_bank < BANKS && items.coef_index < TAPS) begin
						coef_mem[items.coef_bank*TAPS + items.coef_index] =
							longint'(items.coef_value);
					end
				end else begin
					e.smp = out_blk[blk_pos];
					e.sat = clip_blk[blk_pos];
					expected_q.push_back(e);
					in_blk[blk_pos] = longint'(items.sample);
					pend_sel = items.ir_select;
					blk_pos++;
					if (blk_pos >= TAPS) begin
						close_block();
						blk_pos = 0;
					end
				end
			end
			if (results.valid && results.ready) begin
				result_count++;
				if (expected_q.size() == 0) begin
					fail_count++;
					$display("%0t: result %0d/%0b arrived with none expected",
						$time, results.out_sample, results.saturated);
				end else begin
					e = expected_q.pop_front();
					if (results.out_sample !== e.smp) begin
						fail_count++;
						$display("%0t: out_sample expected %0d, got %0d",
							$time, e.smp, results.out_sample);
					end
					if (results.saturated !== e.sat) begin
						fail_count++;
						$display("%0t: saturated expected %0b, got %0b",
							$time, e.sat, results.saturated);
					end
					if (e.sat) begin
						clip_count++;
					end
				end
			end
		end
	end

endmodule

@@ tb/tb.sv @@
// Top of the convolver testbench: clock, reset, item stimulus and result stalls.
// The verdict comes from the failure count of cbc_conv_checker. Depends on the RTL.
`timescale 1ns / 1ps

module tb;

	localparam int TAPS      = 64;
	localparam int BANKS     = 4;
	localparam int IDLE_MAX  = 100000;

	logic clk;
	logic arst_n;
	bit   calm;
	int   fail_count;
	int   pending;
	int   result_count;
	int   fade_count;
	int   clip_count;
	int   quiet_cycles;
	int   sent;
	int   loads;

	cbc_item_if   items ();
	cbc_result_if results ();

	crossfading_block_convolver #(.TAPS(TAPS), .BANKS(BANKS)) DUT (
		.clk(clk), .arst_n(arst_n), .items(items.sink), .results(results.source)
	);

	cbc_conv_checker #(.TAPS(TAPS), .BANKS(BANKS)) checker_i (
		.clk(clk), .arst_n(arst_n), .items(items), .results(results),
		.fail_count(fail_count), .pending(pending), .result_count(result_count),
		.fade_count(fade_count), .clip_count(clip_count)
	);

	// Clock, 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Result side stalls at random, except in the calm stretch.
	always @(posedge clk) begin
		results.ready <= calm || ($urandom_range(99) >= 8);
	end

	// Watchdog on cycles with no transfer on either channel.
	always @(posedge clk) begin
		if ((items.valid && items.ready) || (results.valid && results.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_MAX) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// One item transfer, with an optional random gap before it.
	task automatic send_item(bit k, logic [15:0] smp, logic [2:0] sel,
		logic [1:0] bank, logic [5:0] idx, logic [15:0] cv);
		bit took;
		if (!calm && $urandom_range(99) < 8) begin
			items.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		items.valid      <= 1'b1;
		items.kind       <= k;
		items.sample     <= smp;
		items.ir_select  <= sel;
		items.coef_bank  <= bank;
		items.coef_index <= idx;
		items.coef_value <= cv;
		took = 1'b0;
		while (!took) begin
			@(negedge clk);
			took = items.ready;
			@(posedge clk);
		end
		sent++;
		calm = (sent >= 800 && sent < 1000);
		if (k) begin
			loads++;
		end
	endtask

	task automatic load_coef(logic [1:0] bank, logic [5:0] idx, logic [15:0] cv);
		send_item(1'b1, 16'($urandom), 3'($urandom), bank, idx, cv);
	endtask

	task automatic send_sample(logic [15:0] smp, logic [2:0] sel);
		send_item(1'b0, smp, sel, 2'($urandom), 6'($urandom), 16'($urandom));
	endtask

	initial begin
		logic [15:0] v;
		logic [2:0]  blk_sel;
		items.valid      = 1'b0;
		items.kind       = 1'b0;
		items.sample     = '0;
		items.ir_select  = '0;
		items.coef_bank  = '0;
		items.coef_index = '0;
		items.coef_value = '0;
		results.ready    = 1'b0;
		quiet_cycles     = 0;
		sent             = 0;
		loads            = 0;
		calm             = 1'b0;
		arst_n           = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every response is written before any block can read it:
		// full-range, small, near-impulse and alternating extremes.
		for (int i = 0; i < TAPS; i++) begin
			load_coef(2'd0, 6'(i), 16'($urandom));
			load_coef(2'd1, 6'(i), 16'($urandom_range(512) - 256));
			load_coef(2'd2, 6'(i), (i == 0) ? 16'sd32767 : 16'($urandom_range(6) - 3));
			load_coef(2'd3, 6'(i), (i % 2) ? 16'sh7fff : 16'sh8000);
		end

		// Field extremes, out-of-range selections and a change of response.
		send_sample(16'sh7fff, 3'd0);
		send_sample(16'sh8000, 3'd7);
		send_sample(16'h0000, 3'd4);
		send_sample(16'hffff, 3'd5);
		load_coef(2'd3, 6'd63, 16'sh8000);
		load_coef(2'd0, 6'd0, 16'sh7fff);
		for (int i = 4; i < TAPS - 1; i++) begin
			send_sample((i % 2) ? 16'sh7fff : 16'sh8000, 3'd6);
		end
		send_sample(16'sh7fff, 3'd3);

		// Random part: each block's last sample carries its selection, others a random one at times; occasional reloads.
		blk_sel = 3'd1;
		while (sent < 1400 || (sent - loads) % TAPS != 0) begin
			if ($urandom_range(9) == 0) begin
				v = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(2048) - 1024);
				load_coef(2'($urandom), 6'($urandom), v);
			end else begin
				v = ($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(8192) - 4096);
				if ((sent - loads) % TAPS == TAPS - 1) begin
					send_sample(v, blk_sel);
					blk_sel = 3'($urandom);
				end else begin
					send_sample(v, ($urandom_range(3) == 0) ? 3'($urandom) : blk_sel);
				end
			end
		end
		items.valid <= 1'b0;

		// Drain, then allow for a block pass in case anything stray appears.
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (2 * TAPS * TAPS) @(posedge clk);

		$display("Run covered %0d items: %0d coefficient loads, %0d results checked,",
			sent, loads, result_count);
		$display("%0d crossfaded blocks and %0d clipped outputs.", fade_count, clip_count);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/cbc_pkg.sv
rtl/core/cbc_item_if.sv
rtl/core/cbc_ram.sv
rtl/core/cbc_front.sv
rtl/core/cbc_back.sv
rtl/core/crossfading_block_convolver.sv
tb/cbc_conv_checker.sv
tb/tb.sv
